// ----- sv/alert_hysteresis_confirm_monitor_defines.svh -----
// Assertion macros used by the checker file ahcm_checker.sv.
`ifndef ALERT_HYSTERESIS_CONFIRM_MONITOR_DEFINES_SVH
`define ALERT_HYSTERESIS_CONFIRM_MONITOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AHCM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alert monitor check failed");

// The consequent must hold in the cycle after the antecedent.
`define AHCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alert monitor check failed");

`endif

// ----- sv/ahcm_pkg.sv -----
package ahcm_pkg;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_PENDING  = 2'd1,
    MODE_ACTIVE   = 2'd2,
    MODE_CLEARING = 2'd3
  } mode_t;

  localparam logic [1:0] REG_RAISE_LEVEL   = 2'd0;
  localparam logic [1:0] REG_CLEAR_LEVEL   = 2'd1;
  localparam logic [1:0] REG_CONFIRM_COUNT = 2'd2;
  localparam logic [1:0] REG_RELEASE_COUNT = 2'd3;

  typedef struct packed {
    logic signed [15:0] raise_level;
    logic signed [15:0] clear_level;
    logic [15:0]        confirm_count;
    logic [15:0]        release_count;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] run_length;
    logic [31:0] activations;
    logic [31:0] rejections;
  } state_t;

endpackage

// ----- sv/ahcm_step.sv -----
module ahcm_step
  import ahcm_pkg::*;
(
  input  cfg_t               cfg,
  input  state_t             state,
  input  logic signed [15:0] sample,
  input  logic               sample_invalid,
  output state_t             state_next
);

  logic        high;
  logic        low;
  logic [15:0] run_inc;

  assign high    = sample > cfg.raise_level;
  assign low     = sample < cfg.clear_level;
  assign run_inc = state.run_length + 16'd1;

  always_comb begin
    state_next = state;
    if (sample_invalid) begin
      state_next.rejections = state.rejections + 32'd1;
    end else begin
      case (state.mode)
        MODE_INACTIVE: begin
          if (high) begin
            if (16'd1 >= cfg.confirm_count) begin
              state_next.mode        = MODE_ACTIVE;
              state_next.run_length  = 16'd0;
              state_next.activations = state.activations + 32'd1;
            end else begin
              state_next.mode       = MODE_PENDING;
              state_next.run_length = 16'd1;
            end
          end
        end
        MODE_PENDING: begin
          if (high) begin
            if (run_inc >= cfg.confirm_count) begin
              state_next.mode        = MODE_ACTIVE;
              state_next.run_length  = 16'd0;
              state_next.activations = state.activations + 32'd1;
            end else begin
              state_next.run_length = run_inc;
            end
          end else begin
            state_next.mode       = MODE_INACTIVE;
            state_next.run_length = 16'd0;
          end
        end
        MODE_ACTIVE: begin
          if (low) begin
            if (16'd1 >= cfg.release_count) begin
              state_next.mode       = MODE_INACTIVE;
              state_next.run_length = 16'd0;
            end else begin
              state_next.mode       = MODE_CLEARING;
              state_next.run_length = 16'd1;
            end
          end
        end
        default: begin
          if (low) begin
            if (run_inc >= cfg.release_count) begin
              state_next.mode       = MODE_INACTIVE;
              state_next.run_length = 16'd0;
            end else begin
              state_next.run_length = run_inc;
            end
          end else begin
            state_next.mode       = MODE_ACTIVE;
            state_next.run_length = 16'd0;
          end
        end
      endcase
    end
  end

endmodule

// ----- sv/alert_hysteresis_confirm_monitor.sv -----
// Channel   Handshake             Payload
// input     in_valid / in_stall   sample, sample_invalid
// output    out_valid / out_stall alert_state, activation_total, rejected_total
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is taken every clock unless the output stalls; it passes s1, then state.
// The rate is set by the single update of the state register per item.
// Synchronous reset clears the state and valid flags; levels reset to 0 and -1.
// A stalled result holds the state; the input register still takes one item.
// The configuration port is always ready.
module alert_hysteresis_confirm_monitor
  import ahcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               sample_invalid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         alert_state,
  output logic [31:0]        activation_total,
  output logic [31:0]        rejected_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t               cfg;
  state_t             state;
  state_t             state_next;
  logic               s1_valid;
  logic signed [15:0] s1_sample;
  logic               s1_invalid;
  logic               advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && !(out_valid && out_stall);
  assign in_stall  = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raise_level   <= 16'sd0;
      cfg.clear_level   <= -16'sd1;
      cfg.confirm_count <= 16'd1;
      cfg.release_count <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RAISE_LEVEL:   cfg.raise_level   <= cfg_data;
        REG_CLEAR_LEVEL:   cfg.clear_level   <= cfg_data;
        REG_CONFIRM_COUNT: cfg.confirm_count <= cfg_data;
        REG_RELEASE_COUNT: cfg.release_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample  <= sample;
      s1_invalid <= sample_invalid;
    end
  end

  ahcm_step u_step (
    .cfg            (cfg),
    .state          (state),
    .sample         (s1_sample),
    .sample_invalid (s1_invalid),
    .state_next     (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      state.mode        <= MODE_INACTIVE;
      state.run_length  <= 16'd0;
      state.activations <= 32'd0;
      state.rejections  <= 32'd0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign alert_state      = state.mode;
  assign activation_total = state.activations;
  assign rejected_total   = state.rejections;

endmodule

// ----- sv/ahcm_checker.sv -----
`include "alert_hysteresis_confirm_monitor_defines.svh"

module ahcm_checker
  import ahcm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         alert_state,
  input logic [31:0]        activation_total,
  input logic [31:0]        rejected_total
);

  `AHCM_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && out_stall,
    out_valid && $stable(alert_state) && $stable(activation_total) && $stable(rejected_total))

  `AHCM_ASSERT_IMP(a_activation_step, clk, rst,
    !$past(rst) && activation_total != $past(activation_total),
    activation_total == $past(activation_total) + 32'd1 && alert_state == MODE_ACTIVE
    && $stable(rejected_total))

  `AHCM_ASSERT_IMP(a_rejection_step, clk, rst,
    !$past(rst) && rejected_total != $past(rejected_total),
    rejected_total == $past(rejected_total) + 32'd1 && $stable(alert_state))

  `AHCM_ASSERT_IMP(a_no_direct_hop, clk, rst, !$past(rst),
    !(($past(alert_state) == MODE_INACTIVE || $past(alert_state) == MODE_PENDING)
      && alert_state == MODE_CLEARING)
    && !(($past(alert_state) == MODE_ACTIVE || $past(alert_state) == MODE_CLEARING)
      && alert_state == MODE_PENDING))

endmodule

bind alert_hysteresis_confirm_monitor ahcm_checker u_ahcm_checker (.*);

// ----- tb/ahcm_alert_checker.sv -----
`timescale 1ns / 100ps

module ahcm_alert_checker
  import ahcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               sample_invalid,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         alert_state,
  input  logic [31:0]        activation_total,
  input  logic [31:0]        rejected_total,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_checked
);

  typedef struct packed {
    mode_t       mode;
    logic [31:0] activations;
    logic [31:0] rejections;
  } alert_report_t;

  logic signed [15:0] raise_lvl;
  logic signed [15:0] clear_lvl;
  logic [15:0]        confirm_cnt;
  logic [15:0]        release_cnt;
  mode_t              mode;
  logic [15:0]        run_len;
  logic [31:0]        activations;
  logic [31:0]        rejections;
  alert_report_t      expected_reports[$];

  task automatic report_failure(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic advance_alert_machine(input logic signed [15:0] s, input logic inv);
    logic          high;
    logic          low;
    alert_report_t rep;
    if (inv) begin
      rejections = rejections + 32'd1;
    end else begin
      high = (s > raise_lvl);
      low  = (s < clear_lvl);
      case (mode)
        MODE_INACTIVE: begin
          if (high) begin
            run_len = 16'd1;
            if (run_len >= confirm_cnt) begin
              mode        = MODE_ACTIVE;
              run_len     = 16'd0;
              activations = activations + 32'd1;
            end else begin
              mode = MODE_PENDING;
            end
          end
        end
        MODE_PENDING: begin
          if (high) begin
            run_len = run_len + 16'd1;
            if (run_len >= confirm_cnt) begin
              mode        = MODE_ACTIVE;
              run_len     = 16'd0;
              activations = activations + 32'd1;
            end
          end else begin
            mode    = MODE_INACTIVE;
            run_len = 16'd0;
          end
        end
        MODE_ACTIVE: begin
          if (low) begin
            run_len = 16'd1;
            if (run_len >= release_cnt) begin
              mode    = MODE_INACTIVE;
              run_len = 16'd0;
            end else begin
              mode = MODE_CLEARING;
            end
          end
        end
        default: begin
          if (low) begin
            run_len = run_len + 16'd1;
            if (run_len >= release_cnt) begin
              mode    = MODE_INACTIVE;
              run_len = 16'd0;
            end
          end else begin
            // Falling back to active is not a fresh activation.
            mode    = MODE_ACTIVE;
            run_len = 16'd0;
          end
        end
      endcase
    end
    rep.mode        = mode;
    rep.activations = activations;
    rep.rejections  = rejections;
    expected_reports.push_back(rep);
  endtask

  always @(posedge clk) begin : watch
    alert_report_t want;
    if (rst) begin
      raise_lvl   = 16'sd0;
      clear_lvl   = -16'sd1;
      confirm_cnt = 16'd1;
      release_cnt = 16'd1;
      mode        = MODE_INACTIVE;
      run_len     = 16'd0;
      activations = 32'd0;
      rejections  = 32'd0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RAISE_LEVEL:   raise_lvl = cfg_data;
          REG_CLEAR_LEVEL:   clear_lvl = cfg_data;
          REG_CONFIRM_COUNT: confirm_cnt = cfg_data;
          REG_RELEASE_COUNT: release_cnt = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_reports.size() == 0) begin
          report_failure($sformatf("result with no item outstanding, alert_state %0d",
                                   alert_state));
        end else begin
          want = expected_reports.pop_front();
          if (alert_state !== want.mode)
            report_failure($sformatf("alert_state got %0d expected %0d",
                                     alert_state, want.mode));
          if (activation_total !== want.activations)
            report_failure($sformatf("activation_total got %0d expected %0d",
                                     activation_total, want.activations));
          if (rejected_total !== want.rejections)
            report_failure($sformatf("rejected_total got %0d expected %0d",
                                     rejected_total, want.rejections));
        end
      end
      if (in_valid && !in_stall) begin
        advance_alert_machine(sample, sample_invalid);
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

// ----- tb/tb_alert_hysteresis_confirm_monitor.sv -----
`timescale 1ns / 100ps

module tb_alert_hysteresis_confirm_monitor;
  import ahcm_pkg::*;

  typedef enum int {ZONE_HIGH, ZONE_LOW, ZONE_BETWEEN, ZONE_ANY} zone_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] sample;
  logic               sample_invalid;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         alert_state;
  logic [31:0]        activation_total;
  logic [31:0]        rejected_total;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  int mismatches;
  int outstanding;
  int results_checked;

  int tx_gap_max;
  int rx_wait_max;
  bit hold_pending;
  int samples_sent;
  int invalid_sent;
  int settings_used;
  int cur_raise;
  int cur_clear;

  alert_hysteresis_confirm_monitor dut (.*);

  ahcm_alert_checker alert_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("alert_hysteresis_confirm_monitor test failed");
    $finish;
  end

  initial begin : result_sink
    int w;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        w = 80;
        hold_pending = 1'b0;
      end else begin
        w = $urandom_range(0, rx_wait_max);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_sample(input int value, input bit inv);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    sample         <= value[15:0];
    sample_invalid <= inv;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (inv) invalid_sent++;
  endtask

  task automatic await_drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_levels(input int raise, input int clear, input int confirm,
                                input int rel_cnt);
    await_drain();
    write_reg(REG_RAISE_LEVEL, raise[15:0]);
    write_reg(REG_CLEAR_LEVEL, clear[15:0]);
    write_reg(REG_CONFIRM_COUNT, confirm[15:0]);
    write_reg(REG_RELEASE_COUNT, rel_cnt[15:0]);
    cfg_valid <= 1'b0;
    cur_raise = raise;
    cur_clear = clear;
    settings_used++;
  endtask

  function automatic int zone_sample(input zone_t zone);
    int lo;
    int hi;
    lo = -32768;
    hi = 32767;
    case (zone)
      ZONE_HIGH:    lo = cur_raise + 1;
      ZONE_LOW:     hi = cur_clear - 1;
      ZONE_BETWEEN: begin
        lo = cur_clear;
        hi = cur_raise;
      end
      default: ;
    endcase
    if (lo > hi) begin
      lo = -32768;
      hi = 32767;
    end
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Runs of samples in one zone let the debounce counts complete, with
  // stray samples to break them and invalid samples, which do not, mixed in.
  task automatic run_phase(input int valid_target, input bit do_hold, input bit do_pause);
    zone_t zone;
    int    remaining;
    int    sent;
    int    roll;
    bit    inv;
    bit    midpoint_done;
    zone          = ZONE_ANY;
    remaining     = 0;
    sent          = 0;
    midpoint_done = 1'b0;
    while (sent < valid_target) begin
      if (remaining == 0) begin
        roll = $urandom_range(0, 99);
        zone = (roll < 35) ? ZONE_HIGH : (roll < 70) ? ZONE_LOW :
               (roll < 85) ? ZONE_BETWEEN : ZONE_ANY;
        remaining = $urandom_range(1, 9);
      end
      inv = ($urandom_range(0, 99) < 8);
      send_sample(inv ? zone_sample(ZONE_ANY) : zone_sample(zone), inv);
      if (!inv) begin
        remaining--;
        sent++;
      end
      if (!midpoint_done && sent >= valid_target / 2) begin
        midpoint_done = 1'b1;
        if (do_hold) hold_pending = 1'b1;
        if (do_pause) await_drain();
      end
    end
  endtask

  initial begin : stimulus
    int raise;
    int clear;
    int confirm;
    int rel_cnt;
    rst            = 1'b1;
    in_valid       = 1'b0;
    sample         = 16'sd0;
    sample_invalid = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_RAISE_LEVEL;
    cfg_data       = 16'd0;
    tx_gap_max     = 0;
    rx_wait_max    = 3;
    hold_pending   = 1'b0;
    samples_sent   = 0;
    invalid_sent   = 0;
    settings_used  = 1;
    cur_raise      = 0;
    cur_clear      = -1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(0, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(-2, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-32768, 1'b0);

    program_levels(100, -100, 3, 2);
    send_sample(101, 1'b0);
    send_sample(101, 1'b0);
    send_sample(100, 1'b0);
    send_sample(200, 1'b0);
    send_sample(300, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-101, 1'b0);
    send_sample(-100, 1'b0);
    send_sample(-32768, 1'b1);
    send_sample(-200, 1'b0);
    send_sample(-300, 1'b0);

    program_levels(0, 0, 0, 0);
    send_sample(1, 1'b0);
    send_sample(-1, 1'b0);

    program_levels(-10, 10, 2, 2);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(20, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);

    for (int p = 0; p < 12; p++) begin
      raise   = int'($urandom_range(0, 60000)) - 30000;
      clear   = raise - int'($urandom_range(0, 3000));
      confirm = $urandom_range(1, 6);
      rel_cnt = $urandom_range(1, 6);
      case (p)
        0: begin
          raise = 32767;
          clear = -32768;
        end
        1: begin
          raise   = -32768;
          clear   = 32767;
          confirm = 1;
          rel_cnt = 1;
        end
        2: begin
          confirm = 0;
          rel_cnt = 0;
        end
        3: begin
          confirm = 65535;
          rel_cnt = 65535;
        end
        9: clear = raise + int'($urandom_range(0, 3000));
        default: ;
      endcase
      if (clear > 32767) clear = 32767;
      if (clear < -32768) clear = -32768;
      program_levels(raise, clear, confirm, rel_cnt);
      tx_gap_max  = (p % 3 == 1) ? 0 : 16;
      rx_wait_max = (p % 4 == 2) ? 0 : 16;
      run_phase(117, p == 5, p == 7);
    end

    await_drain();
    repeat (8) @(posedge clk);

    if (outstanding != 0) begin
      $display("%0d results never arrived", outstanding);
    end
    $display("Sent %0d samples (%0d marked invalid) under %0d register settings,",
             samples_sent, invalid_sent, settings_used);
    $display("%s %0d results checked.",
             "including crossed and full-scale levels, zero and maximum counts;",
             results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("alert_hysteresis_confirm_monitor test passed");
    end else begin
      $display("alert_hysteresis_confirm_monitor test failed");
    end
    $finish;
  end

endmodule

// ----- alert_hysteresis_confirm_monitor.f -----
+incdir+sv
sv/ahcm_pkg.sv
sv/ahcm_step.sv
sv/alert_hysteresis_confirm_monitor.sv
sv/ahcm_checker.sv
tb/ahcm_alert_checker.sv
tb/tb_alert_hysteresis_confirm_monitor.sv
